>>> rtl/rilp_pkg.sv
`default_nettype none

package rilp_pkg;

	localparam int VALUE_BITS_DEF = 64;
	localparam int CHAR_BITS_DEF  = 21;
	localparam int CP_W           = 21;
	localparam int VALUE_W        = 64;

	// phase codes
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_HASH   = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;

	// radix codes
	localparam logic [1:0] RADIX_BIN = 2'd0;
	localparam logic [1:0] RADIX_OCT = 2'd1;
	localparam logic [1:0] RADIX_DEC = 2'd2;
	localparam logic [1:0] RADIX_HEX = 2'd3;

	// error codes
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_NO_DIGITS = 2'd1;
	localparam logic [1:0] ERR_RADIX     = 2'd2;

	// characters
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_F = 8'h66;
	localparam logic [7:0] CH_LOW_H = 8'h68;
	localparam logic [7:0] CH_LOW_O = 8'h6F;

	typedef struct packed {
		logic              ok;
		logic [1:0]        error_code;
		logic [VALUE_W-1:0] value;
		logic [1:0]        radix;
		logic              suffix_taken;
		logic              saturated;
	} result_t;

	function automatic logic [3:0] radix_top(input logic [1:0] r);
		logic [3:0] t;
		unique case (r)
			RADIX_BIN: t = 4'd1;
			RADIX_OCT: t = 4'd7;
			RADIX_DEC: t = 4'd9;
			default:   t = 4'd15;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

>>> rtl/radix_integer_literal_parser.sv
// An item is taken into the input register (valid_s1, cp_s1, end_s1); its result (if any)
// is written into the output register (res_q, m_axis_tvalid) when the core steps on it.
// Throughput: one item per cycle; the input stage stalls only while the output
// register holds a result that has not been taken.
// Reset: asynchronous, clears parser state and both valid flags; default_base = 2.
`default_nettype none

module radix_integer_literal_parser #(
	parameter int VALUE_BITS = rilp_pkg::VALUE_BITS_DEF,
	parameter int CHAR_BITS  = rilp_pkg::CHAR_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_wdata,     // default_base
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // code_point[20:0], zero pad
	input  wire logic        s_axis_tuser,  // text_end
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [71:0]      m_axis_tdata,  // error_code, value[63:0], radix,
	                                        // suffix_taken, saturated, zero pad
	output logic             m_axis_tuser   // ok
);

	logic [1:0]                    base_q;
	logic                          valid_s1;
	logic [rilp_pkg::CP_W-1:0]     cp_s1;
	logic                          end_s1;
	logic                          out_free, step;
	logic                          res_valid;
	rilp_pkg::result_t             res, res_q;

	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = !valid_s1 || out_free;
	assign step          = valid_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= rilp_pkg::RADIX_DEC;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cp_s1  <= s_axis_tdata[rilp_pkg::CP_W-1:0];
			end_s1 <= s_axis_tuser;
		end
	end

	rilp_core #(
		.VALUE_BITS (VALUE_BITS),
		.CHAR_BITS  (CHAR_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.cp        (cp_s1),
		.text_end  (end_s1),
		.base      (base_q),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (step && res_valid) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			res_q <= res;
		end
	end

	assign m_axis_tuser = res_q.ok;
	assign m_axis_tdata = {2'b00, res_q.saturated, res_q.suffix_taken, res_q.radix,
	                       res_q.value, res_q.error_code};

endmodule

`default_nettype wire

>>> rtl/rilp_fold.sv
`default_nettype none

module rilp_fold #(
	parameter int         VALUE_BITS = rilp_pkg::VALUE_BITS_DEF,
	parameter logic [1:0] RADIX      = rilp_pkg::RADIX_DEC
) (
	input  wire logic [VALUE_BITS-1:0] acc,
	input  wire logic                  mark,
	input  wire logic [3:0]            digit,
	output logic      [VALUE_BITS-1:0] acc_next,
	output logic                       mark_next
);

	logic [VALUE_BITS+3:0] ext;
	logic [VALUE_BITS+3:0] dig_ext;
	logic [VALUE_BITS+3:0] prod;

	// acc * base + digit, four spare bits catch any overflow
	always_comb begin
		ext     = {4'b0000, acc};
		dig_ext = {{VALUE_BITS{1'b0}}, digit};
		case (RADIX)
			rilp_pkg::RADIX_BIN: prod = (ext << 1) + dig_ext;
			rilp_pkg::RADIX_OCT: prod = (ext << 3) + dig_ext;
			rilp_pkg::RADIX_DEC: prod = (ext << 3) + (ext << 1) + dig_ext;
			default:             prod = (ext << 4) + dig_ext;
		endcase
		if (mark) begin
			acc_next  = acc;
			mark_next = 1'b1;
		end else if (prod[VALUE_BITS+3:VALUE_BITS] != 4'd0) begin
			acc_next  = '1;
			mark_next = 1'b1;
		end else begin
			acc_next  = prod[VALUE_BITS-1:0];
			mark_next = 1'b0;
		end
	end

endmodule

`default_nettype wire

>>> rtl/rilp_core.sv
`default_nettype none

module rilp_core #(
	parameter int VALUE_BITS = rilp_pkg::VALUE_BITS_DEF,
	parameter int CHAR_BITS  = rilp_pkg::CHAR_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic [rilp_pkg::CP_W-1:0]  cp,
	input  wire logic                       text_end,
	input  wire logic [1:0]                 base,
	output logic                            res_valid,
	output rilp_pkg::result_t               res
);

	logic [1:0]            phase_q;
	logic [VALUE_BITS-1:0] acc_q [4];
	logic [3:0]            marks_q;
	logic [3:0]            largest_q;
	logic                  any_q;

	logic [VALUE_BITS-1:0] acc_d [4];
	logic [3:0]            marks_d;

	logic [CHAR_BITS-1:0] cp_c;
	logic                 is_num, is_up, is_low, is_hex;
	logic                 is_hash, is_space, is_h, is_o;
	logic [3:0]           hv;

	logic [1:0] phase_d;
	logic       clear, fold_en, fin, fin_suf;
	logic [1:0] suf_r, r;
	logic [63:0] val;

	always_comb begin
		cp_c     = cp[CHAR_BITS-1:0];
		is_num   = cp_c >= CHAR_BITS'(rilp_pkg::CH_0) && cp_c <= CHAR_BITS'(rilp_pkg::CH_9);
		is_up    = cp_c >= CHAR_BITS'(rilp_pkg::CH_UP_A) &&
		           cp_c <= CHAR_BITS'(rilp_pkg::CH_UP_F);
		is_low   = cp_c >= CHAR_BITS'(rilp_pkg::CH_LOW_A) &&
		           cp_c <= CHAR_BITS'(rilp_pkg::CH_LOW_F);
		is_hex   = is_num || is_up || is_low;
		is_hash  = cp_c == CHAR_BITS'(rilp_pkg::CH_HASH);
		is_space = cp_c == CHAR_BITS'(rilp_pkg::CH_SPACE);
		is_h     = cp_c == CHAR_BITS'(rilp_pkg::CH_LOW_H);
		is_o     = cp_c == CHAR_BITS'(rilp_pkg::CH_LOW_O);
		// letters: low nibble 1..6 plus 9 gives 10..15
		hv       = is_num ? cp_c[3:0] : cp_c[3:0] + 4'd9;
	end

	for (genvar g = 0; g < 4; g++) begin : g_fold
		rilp_fold #(
			.VALUE_BITS (VALUE_BITS),
			.RADIX      (2'(g))
		) u_fold (
			.acc       (acc_q[g]),
			.mark      (marks_q[g]),
			.digit     (hv),
			.acc_next  (acc_d[g]),
			.mark_next (marks_d[g])
		);
	end

	always_comb begin
		phase_d = phase_q;
		clear   = 1'b0;
		fold_en = 1'b0;
		fin     = 1'b0;
		fin_suf = 1'b0;
		suf_r   = rilp_pkg::RADIX_HEX;
		unique case (phase_q) inside
			rilp_pkg::PH_HASH, rilp_pkg::PH_DIGITS: begin
				if (text_end) begin
					fin     = 1'b1;
					phase_d = rilp_pkg::PH_IDLE;
				end else if (phase_q == rilp_pkg::PH_HASH && is_space) begin
					phase_d = rilp_pkg::PH_DIGITS;
				end else if (is_hex) begin
					fold_en = 1'b1;
					phase_d = rilp_pkg::PH_DIGITS;
				end else if (is_h) begin
					fin     = 1'b1;
					fin_suf = 1'b1;
					suf_r   = rilp_pkg::RADIX_HEX;
					phase_d = rilp_pkg::PH_IDLE;
				end else if (is_o) begin
					fin     = 1'b1;
					fin_suf = 1'b1;
					suf_r   = rilp_pkg::RADIX_OCT;
					phase_d = rilp_pkg::PH_IDLE;
				end else begin
					// ending char falls through as idle input
					fin = 1'b1;
					if (is_hash) begin
						clear   = 1'b1;
						phase_d = rilp_pkg::PH_HASH;
					end else begin
						phase_d = rilp_pkg::PH_IDLE;
					end
				end
			end
			default: begin
				if (!text_end && is_hash) begin
					clear   = 1'b1;
					phase_d = rilp_pkg::PH_HASH;
				end else begin
					phase_d = rilp_pkg::PH_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		r   = fin_suf ? suf_r : base;
		val = '0;
		res = '0;
		res.radix        = r;
		res.suffix_taken = fin_suf;
		if (!any_q) begin
			res.error_code = rilp_pkg::ERR_NO_DIGITS;
		end else if (largest_q > rilp_pkg::radix_top(r)) begin
			res.error_code = rilp_pkg::ERR_RADIX;
		end else begin
			res.error_code = rilp_pkg::ERR_NONE;
		end
		if (res.error_code == rilp_pkg::ERR_NONE) begin
			val[VALUE_BITS-1:0] = acc_q[r];
			res.ok              = 1'b1;
			res.value           = val;
			res.saturated       = marks_q[r];
		end
		res_valid = fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= rilp_pkg::PH_IDLE;
			marks_q   <= '0;
			largest_q <= '0;
			any_q     <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				acc_q[i] <= '0;
			end
		end else if (step) begin
			phase_q <= phase_d;
			if (clear) begin
				marks_q   <= '0;
				largest_q <= '0;
				any_q     <= 1'b0;
				for (int i = 0; i < 4; i++) begin
					acc_q[i] <= '0;
				end
			end else if (fold_en) begin
				marks_q <= marks_d;
				any_q   <= 1'b1;
				if (hv > largest_q) begin
					largest_q <= hv;
				end
				for (int i = 0; i < 4; i++) begin
					acc_q[i] <= acc_d[i];
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_ok_has_digits: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid && res.ok |-> any_q)
		else $error("literal accepted without digits");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.ok |-> res.value == '0 && !res.saturated)
		else $error("error result carries value or saturation");

	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && text_end && phase_q == rilp_pkg::PH_DIGITS |=> phase_q == rilp_pkg::PH_IDLE)
		else $error("text end did not close the literal");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == rilp_pkg::PH_IDLE && !text_end && is_hash
		|=> phase_q == rilp_pkg::PH_HASH && !any_q && marks_q == 4'd0)
		else $error("literal start left stale state");
`endif

endmodule

`default_nettype wire
